// File: rtl/sgd_pkg.sv
`timescale 1ns / 1ps

package sgd_pkg;

    // Default sample width, 4096 LSB per g at 16 bits
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int TIME_W      = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int STREAK_W    = 8;
    localparam int COUNT_W     = 4;
    localparam int OUT_DATA_W  = 8;

    // Squared thresholds in LSB^2 (1 g = 4096 LSB)
    localparam logic [31:0] DEV_HIGH_SQ = 32'd42949672;  // 1.6 g
    localparam logic [31:0] DEV_LOW_SQ  = 32'd2684355;   // 0.4 g
    localparam logic [31:0] MIN_MAG_SQ  = 32'd2055208;   // 0.35 g
    localparam logic [31:0] QUIET_LO_SQ = 32'd10737418;  // 0.8 g
    localparam logic [31:0] QUIET_HI_SQ = 32'd24159192;  // 1.2 g

    localparam logic [STREAK_W-1:0] STREAK_MAX = '1;
    localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;

    // Register reset values
    localparam logic        RST_SHAKE_ENABLE  = 1'b1;
    localparam logic        RST_OBSERVE_ONLY  = 1'b0;
    localparam logic [3:0]  RST_MIN_STREAK    = 4'd3;
    localparam logic [3:0]  RST_SWINGS_NEEDED = 4'd4;
    localparam logic [15:0] RST_QUIET_MS      = 16'd500;
    localparam logic [15:0] RST_COOLDOWN_MS   = 16'd2000;
    localparam logic [15:0] RST_PEND_TMO_MS   = 16'd2500;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SHAKE_ENABLE  = 3'd0,
        REG_OBSERVE_ONLY  = 3'd1,
        REG_MIN_STREAK    = 3'd2,
        REG_SWINGS_NEEDED = 3'd3,
        REG_QUIET_MS      = 3'd4,
        REG_COOLDOWN_MS   = 3'd5,
        REG_PEND_TMO_MS   = 3'd6
    } sgd_reg_t;

    typedef struct packed {
        logic        shake_enable;
        logic        observe_only;
        logic [3:0]  min_streak;
        logic [3:0]  swings_needed;
        logic [15:0] quiet_ms;
        logic [15:0] cooldown_ms;
        logic [15:0] pending_timeout_ms;
    } sgd_cfg_t;

    // Per-sample magnitude classification
    typedef struct packed {
        logic dev_big;    // |mag - 1g| > 0.6 g
        logic dev_small;  // |mag - 1g| < 0.2 g
        logic mag_ok;     // mag > 0.35 g
    } sgd_flags_t;

endpackage

// File: rtl/sgd_mag.sv
`timescale 1ns / 1ps

module sgd_mag #(
    parameter int SAMPLE_WIDTH = sgd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]    accel_x,
    input  logic signed [SAMPLE_WIDTH-1:0]    accel_y,
    input  logic signed [SAMPLE_WIDTH-1:0]    accel_z,
    input  logic [sgd_pkg::TIME_W-1:0]        time_ms,
    output logic                              out_valid,
    input  logic                              out_ready,
    output sgd_pkg::sgd_flags_t               flags,
    output logic [sgd_pkg::TIME_W-1:0]        out_time_ms
);

    localparam int SQ_W  = 2 * SAMPLE_WIDTH;
    localparam int CMP_W = (SQ_W > 32) ? SQ_W : 32;

    logic                              s1_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0]    x_reg, y_reg, z_reg;
    logic [sgd_pkg::TIME_W-1:0]        t1_reg;
    logic                              s2_valid_reg;
    sgd_pkg::sgd_flags_t               flags_reg, flags_next;
    logic [sgd_pkg::TIME_W-1:0]        t2_reg;

    logic                              s1_ready, s2_ready;
    logic [SAMPLE_WIDTH-1:0]           ax, ay, az;
    logic [SQ_W-1:0]                   sq_x, sq_y, sq_z, msq;
    logic [CMP_W-1:0]                  msq_ext;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Magnitude of -2^(W-1) still fits as unsigned
    assign ax = x_reg[SAMPLE_WIDTH-1] ? (~x_reg + 1'b1) : x_reg;
    assign ay = y_reg[SAMPLE_WIDTH-1] ? (~y_reg + 1'b1) : y_reg;
    assign az = z_reg[SAMPLE_WIDTH-1] ? (~z_reg + 1'b1) : z_reg;

    assign sq_x = SQ_W'(ax) * SQ_W'(ax);
    assign sq_y = SQ_W'(ay) * SQ_W'(ay);
    assign sq_z = SQ_W'(az) * SQ_W'(az);
    // Sum is at most 3 * 2^(2W-2), no overflow
    assign msq     = sq_x + sq_y + sq_z;
    assign msq_ext = CMP_W'(msq);

    always_comb
    begin
        flags_next.dev_big   = (msq_ext > CMP_W'(sgd_pkg::DEV_HIGH_SQ)) ||
                               (msq_ext < CMP_W'(sgd_pkg::DEV_LOW_SQ));
        flags_next.dev_small = (msq_ext > CMP_W'(sgd_pkg::QUIET_LO_SQ)) &&
                               (msq_ext < CMP_W'(sgd_pkg::QUIET_HI_SQ));
        flags_next.mag_ok    = (msq_ext > CMP_W'(sgd_pkg::MIN_MAG_SQ));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            x_reg  <= accel_x;
            y_reg  <= accel_y;
            z_reg  <= accel_z;
            t1_reg <= time_ms;
        end
        if (s1_valid_reg && s2_ready)
        begin
            flags_reg <= flags_next;
            t2_reg    <= t1_reg;
        end
    end

    assign out_valid   = s2_valid_reg;
    assign flags       = flags_reg;
    assign out_time_ms = t2_reg;

endmodule

// File: rtl/sgd_track.sv
`timescale 1ns / 1ps

module sgd_track (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sgd_pkg::sgd_cfg_t           cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  sgd_pkg::sgd_flags_t         flags,
    input  logic [sgd_pkg::TIME_W-1:0]  time_ms,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        shake_fired,
    output logic                        would_fire,
    output logic                        gesture_pending
);

    localparam int TW = sgd_pkg::TIME_W;

    logic [sgd_pkg::STREAK_W-1:0] streak_len_reg, streak_len_next;
    logic                         streak_low_reg, streak_low_next;
    logic [sgd_pkg::COUNT_W-1:0]  swing_count_reg, swing_count_next;
    logic [TW-1:0]                last_swing_reg, last_swing_next;
    logic                         pending_reg, pending_next;
    logic [TW-1:0]                pend_start_reg, pend_start_next;
    logic [TW-1:0]                last_fire_reg, last_fire_next;

    logic                         out_valid_reg;
    logic                         fired_reg, fired_next;
    logic                         would_reg, would_next;
    logic                         pend_out_reg;

    logic                         accept;
    logic [3:0]                   need;
    logic                         swing;
    logic [sgd_pkg::COUNT_W-1:0]  cnt_base;
    logic                         fire;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign need     = (cfg.min_streak == 4'd0) ? 4'd1 : cfg.min_streak;

    always_comb
    begin
        streak_len_next  = streak_len_reg;
        streak_low_next  = streak_low_reg;
        swing_count_next = swing_count_reg;
        last_swing_next  = last_swing_reg;
        pending_next     = pending_reg;
        pend_start_next  = pend_start_reg;
        last_fire_next   = last_fire_reg;
        fired_next       = 1'b0;
        would_next       = 1'b0;
        swing            = 1'b0;
        cnt_base         = swing_count_reg;
        fire             = 1'b0;

        if (cfg.shake_enable || cfg.observe_only)
        begin
            if (flags.dev_big)
            begin
                if (streak_len_reg != sgd_pkg::STREAK_MAX)
                    streak_len_next = streak_len_reg + 1'b1;
                streak_low_next = streak_low_reg || !flags.mag_ok;
            end
            else
            begin
                swing = (streak_len_reg >= sgd_pkg::STREAK_W'(need)) &&
                        !streak_low_reg && !pending_reg;
                if (swing)
                begin
                    // Swing too far after the previous one restarts the count
                    if ((swing_count_reg != '0) &&
                        ((time_ms - last_swing_reg) > TW'(cfg.quiet_ms)))
                        cnt_base = '0;
                    swing_count_next = (cnt_base != sgd_pkg::COUNT_MAX) ?
                                       cnt_base + 1'b1 : cnt_base;
                    last_swing_next  = time_ms;
                    if (swing_count_next >= cfg.swings_needed)
                    begin
                        pending_next    = 1'b1;
                        pend_start_next = time_ms;
                    end
                end
                streak_len_next = '0;
                streak_low_next = 1'b0;
            end

            fire = pending_next && flags.dev_small &&
                   ((time_ms - last_swing_next) >= TW'(cfg.quiet_ms)) &&
                   ((time_ms - last_fire_reg) >= TW'(cfg.cooldown_ms));
            if (fire)
            begin
                pending_next     = 1'b0;
                swing_count_next = '0;
                last_fire_next   = time_ms;
                would_next       = cfg.observe_only;
                fired_next       = !cfg.observe_only;
            end

            if (pending_next &&
                ((time_ms - pend_start_next) > TW'(cfg.pending_timeout_ms)))
            begin
                pending_next     = 1'b0;
                swing_count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            streak_len_reg  <= '0;
            streak_low_reg  <= 1'b0;
            swing_count_reg <= '0;
            last_swing_reg  <= '0;
            pending_reg     <= 1'b0;
            pend_start_reg  <= '0;
            last_fire_reg   <= '0;
        end
        else
        begin
            if (in_ready)
                out_valid_reg <= in_valid;
            if (accept)
            begin
                streak_len_reg  <= streak_len_next;
                streak_low_reg  <= streak_low_next;
                swing_count_reg <= swing_count_next;
                last_swing_reg  <= last_swing_next;
                pending_reg     <= pending_next;
                pend_start_reg  <= pend_start_next;
                last_fire_reg   <= last_fire_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fired_reg    <= fired_next;
            would_reg    <= would_next;
            pend_out_reg <= pending_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign shake_fired     = fired_reg;
    assign would_fire      = would_reg;
    assign gesture_pending = pend_out_reg;

endmodule

// File: rtl/shake_gesture_detector_top.sv
`timescale 1ns / 1ps

// Shake gesture detector. Each input item is one accelerometer sample
// (x, y, z, two's complement, 4096 LSB per g at 16 bits) plus a millisecond
// timestamp; each item yields exactly one result item carrying shake_fired,
// would_fire and the pending flag after that sample. Throughput is one item
// per clock while m_tready is not held low; each item passes in order
// through three register stages: sample register, magnitude-class
// register (squares, sum and threshold compares) and result register
// (swing/pending/fire state update). The input side keeps accepting while
// a result waits, until all three stages are full. Configuration registers
// are written through the cfg channel, which is always ready; write them
// only while no item is in flight.

module shake_gesture_detector_top #(
    parameter int SAMPLE_WIDTH = sgd_pkg::SAMPLE_WIDTH_DEF,
    localparam int IN_DATA_W   = ((3 * SAMPLE_WIDTH + sgd_pkg::TIME_W + 7) / 8) * 8
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    // accel_x, accel_y, accel_z, time_ms (from bit 0), zero padded
    input  logic [IN_DATA_W-1:0]               s_tdata,

    output logic                               m_tvalid,
    input  logic                               m_tready,
    // shake_fired, would_fire, gesture_pending (from bit 0), zero padded
    output logic [sgd_pkg::OUT_DATA_W-1:0]     m_tdata,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sgd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sgd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int TW = sgd_pkg::TIME_W;

    sgd_pkg::sgd_cfg_t               cfg_reg;
    logic signed [SAMPLE_WIDTH-1:0]  accel_x, accel_y, accel_z;
    logic [TW-1:0]                   time_ms;

    logic                            mid_valid, mid_ready;
    sgd_pkg::sgd_flags_t             mid_flags;
    logic [TW-1:0]                   mid_time;

    logic                            shake_fired, would_fire, gesture_pending;

    // ---------------- input unpack ----------------
    assign accel_x = s_tdata[SAMPLE_WIDTH-1:0];
    assign accel_y = s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
    assign accel_z = s_tdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH];
    assign time_ms = s_tdata[3*SAMPLE_WIDTH+TW-1:3*SAMPLE_WIDTH];

    // ---------------- configuration registers ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.shake_enable       <= sgd_pkg::RST_SHAKE_ENABLE;
            cfg_reg.observe_only       <= sgd_pkg::RST_OBSERVE_ONLY;
            cfg_reg.min_streak         <= sgd_pkg::RST_MIN_STREAK;
            cfg_reg.swings_needed      <= sgd_pkg::RST_SWINGS_NEEDED;
            cfg_reg.quiet_ms           <= sgd_pkg::RST_QUIET_MS;
            cfg_reg.cooldown_ms        <= sgd_pkg::RST_COOLDOWN_MS;
            cfg_reg.pending_timeout_ms <= sgd_pkg::RST_PEND_TMO_MS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (sgd_pkg::sgd_reg_t'(cfg_index))
                sgd_pkg::REG_SHAKE_ENABLE:  cfg_reg.shake_enable       <= cfg_data[0];
                sgd_pkg::REG_OBSERVE_ONLY:  cfg_reg.observe_only       <= cfg_data[0];
                sgd_pkg::REG_MIN_STREAK:    cfg_reg.min_streak         <= cfg_data[3:0];
                sgd_pkg::REG_SWINGS_NEEDED: cfg_reg.swings_needed      <= cfg_data[3:0];
                sgd_pkg::REG_QUIET_MS:      cfg_reg.quiet_ms           <= cfg_data;
                sgd_pkg::REG_COOLDOWN_MS:   cfg_reg.cooldown_ms        <= cfg_data;
                sgd_pkg::REG_PEND_TMO_MS:   cfg_reg.pending_timeout_ms <= cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // ---------------- magnitude classification (stages 1-2) ----------------
    sgd_mag #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mag (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .accel_x     (accel_x),
        .accel_y     (accel_y),
        .accel_z     (accel_z),
        .time_ms     (time_ms),
        .out_valid   (mid_valid),
        .out_ready   (mid_ready),
        .flags       (mid_flags),
        .out_time_ms (mid_time)
    );

    // ---------------- gesture state and result register (stage 3) ----------------
    sgd_track u_track (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .in_valid        (mid_valid),
        .in_ready        (mid_ready),
        .flags           (mid_flags),
        .time_ms         (mid_time),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .shake_fired     (shake_fired),
        .would_fire      (would_fire),
        .gesture_pending (gesture_pending)
    );

    assign m_tdata = {{(sgd_pkg::OUT_DATA_W-3){1'b0}}, gesture_pending, would_fire, shake_fired};

    // ---------------- assertions ----------------
    // A fire and a would-fire never come together
    a_fire_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(shake_fired && would_fire))
        else $error("shake_fired and would_fire both set");

    // Firing always clears the pending flag
    a_fire_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (shake_fired || would_fire)) |-> !gesture_pending)
        else $error("pending still set after fire");

    // would_fire only in observe-only mode
    a_would_needs_observe: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && would_fire) |-> cfg_reg.observe_only)
        else $error("would_fire without observe_only");

    // Input stalls only when every stage holds an item and the output is blocked
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready && mid_valid))
        else $error("input stalled with room in pipeline");

endmodule
